/* hw/rtl/bpc_pkg.sv */
// Package: shared widths, pipeline stage numbers, types and helpers for the barometer compensator.
`default_nettype none
package bpc_pkg;

    localparam int RAW_W       = 20;
    localparam int CAL_W       = 16;
    localparam int DATA_W      = 64;
    localparam int QUEUE_DEPTH = 4;

    // Stage numbers of the back pipeline
    localparam int S_TEMP  = 5;
    localparam int S_NUM   = 13;
    localparam int DIV_LAT = DATA_W + 2;
    localparam int S_Q     = S_NUM + DIV_LAT;
    localparam int S_OUT   = S_Q + 6;

    localparam logic [63:0] P_OFFSET    = 64'd1048576;
    localparam logic [63:0] FINE_OFFSET = 64'd128000;
    localparam logic [63:0] P_SCALE     = 64'd3125;
    localparam logic [63:0] V1_BIAS     = 64'h0000_8000_0000_0000;

    typedef enum logic [1:0] {
        CAL_TEMP    = 2'd0,
        CAL_PRESS_A = 2'd1,
        CAL_PRESS_B = 2'd2,
        CAL_PRESS_C = 2'd3
    } cal_idx_t;

    typedef struct packed {
        logic [RAW_W-1:0] adc_p;
        logic [RAW_W-1:0] adc_t;
    } raw_t;

    typedef struct packed {
        logic valid;
        raw_t raw;
    } q_head_t;

    typedef struct packed {
        logic [CAL_W-1:0] t1;
        logic [CAL_W-1:0] t2;
        logic [CAL_W-1:0] t3;
        logic [CAL_W-1:0] p1;
        logic [CAL_W-1:0] p2;
        logic [CAL_W-1:0] p3;
        logic [CAL_W-1:0] p4;
        logic [CAL_W-1:0] p5;
        logic [CAL_W-1:0] p6;
        logic [CAL_W-1:0] p7;
        logic [CAL_W-1:0] p8;
        logic [CAL_W-1:0] p9;
    } cal_t;

    function automatic logic [63:0] sx16(input logic [CAL_W-1:0] v);
        return {{(64-CAL_W){v[CAL_W-1]}}, v};
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/bpc_if.sv */
// Interfaces: raw measurement channel and compensated result channel.
`default_nettype none
interface bpc_meas_if;
    logic       valid;
    logic       ready;
    logic [7:0] press_msb;
    logic [7:0] press_lsb;
    logic [7:0] press_xlsb;
    logic [7:0] temp_msb;
    logic [7:0] temp_lsb;
    logic [7:0] temp_xlsb;

    modport source (output valid, press_msb, press_lsb, press_xlsb,
                    temp_msb, temp_lsb, temp_xlsb, input ready);
    modport sink   (input valid, press_msb, press_lsb, press_xlsb,
                    temp_msb, temp_lsb, temp_xlsb, output ready);
endinterface

interface bpc_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic               pressure_invalid;

    modport source (output valid, temperature_centi, pressure_q24_8, pressure_invalid,
                    input ready);
    modport sink   (input valid, temperature_centi, pressure_q24_8, pressure_invalid,
                    output ready);
endinterface
`default_nettype wire

/* hw/rtl/baro_temp_pressure_compensation.sv */
// Top level: barometric temperature and pressure compensation.
//
//  channel  | dir | payload                                         | handshake
//  ---------+-----+-------------------------------------------------+-------------
//  meas     | in  | press_msb/lsb/xlsb, temp_msb/lsb/xlsb (8b each)  | valid/ready
//  result   | out | temperature_centi, pressure_q24_8, invalid flag  | valid/ready
//  cfg      | in  | cfg_index (2b), cfg_wdata (64b)                  | cfg_we only
//
// One beat per cycle sustained while result is not stalled; most of each beat's
// path from leaving the queue to showing on result is the 66-stage divider.
// Reset is asynchronous, active low; it empties the queue and pipeline and
// clears the calibration registers. A stalled result freezes the whole back
// pipeline; the queue keeps taking beats until it is full.
`default_nettype none
module baro_temp_pressure_compensation #(
    parameter int QUEUE_DEPTH = bpc_pkg::QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    bpc_meas_if.sink         meas,
    bpc_res_if.source        result,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_wdata
);
    // calibration words; the user must write them only while idle, the block does not enforce it
    logic [47:0] cal_temp_reg;
    logic [63:0] cal_press_a_reg;
    logic [63:0] cal_press_b_reg;
    logic [15:0] cal_press_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_temp_reg    <= '0;
            cal_press_a_reg <= '0;
            cal_press_b_reg <= '0;
            cal_press_c_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (bpc_pkg::cal_idx_t'(cfg_index))
                bpc_pkg::CAL_TEMP:    cal_temp_reg    <= cfg_wdata[47:0];
                bpc_pkg::CAL_PRESS_A: cal_press_a_reg <= cfg_wdata;
                bpc_pkg::CAL_PRESS_B: cal_press_b_reg <= cfg_wdata;
                bpc_pkg::CAL_PRESS_C: cal_press_c_reg <= cfg_wdata[15:0];
                default:              cal_temp_reg    <= cal_temp_reg;
            endcase
        end
    end

    // slice the packed words into coefficients
    bpc_pkg::cal_t cal;
    assign cal.t1 = cal_temp_reg[15:0];
    assign cal.t2 = cal_temp_reg[31:16];
    assign cal.t3 = cal_temp_reg[47:32];
    assign cal.p1 = cal_press_a_reg[15:0];
    assign cal.p2 = cal_press_a_reg[31:16];
    assign cal.p3 = cal_press_a_reg[47:32];
    assign cal.p4 = cal_press_a_reg[63:48];
    assign cal.p5 = cal_press_b_reg[15:0];
    assign cal.p6 = cal_press_b_reg[31:16];
    assign cal.p7 = cal_press_b_reg[47:32];
    assign cal.p8 = cal_press_b_reg[63:48];
    assign cal.p9 = cal_press_c_reg;

    bpc_pkg::q_head_t q_head;
    logic             pop;

    // front: unpack and queue
    bpc_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .meas  (meas),
        .pop   (pop),
        .head  (q_head)
    );

    // back: compensation pipeline and result register
    bpc_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (q_head),
        .cal    (cal),
        .pop    (pop),
        .result (result)
    );

    // the back never pulls from an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_head.valid)
        else $error("pop from empty queue");

    // a zero divisor always forces pressure to zero
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.pressure_invalid) |-> (result.pressure_q24_8 == 32'd0))
        else $error("invalid pressure not zeroed");

    // P9 write lands in its register
    a_cfg_p9: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && (cfg_index == bpc_pkg::CAL_PRESS_C))
            |=> (cal_press_c_reg == $past(cfg_wdata[15:0])))
        else $error("P9 write lost");

endmodule
`default_nettype wire

/* hw/rtl/bpc_front.sv */
// Front: accepts raw beats, unpacks the 20-bit values and queues them.
`default_nettype none
module bpc_front #(
    parameter int DEPTH = bpc_pkg::QUEUE_DEPTH
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    bpc_meas_if.sink          meas,
    input  wire logic         pop,
    output bpc_pkg::q_head_t  head
);
    localparam int AW = $clog2(DEPTH);

    bpc_pkg::raw_t   mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [AW:0]     count_reg, count_next;
    logic            push;
    logic            do_pop;
    bpc_pkg::raw_t   unpacked;

    assign meas.ready = (count_reg != (AW+1)'(DEPTH));
    assign push       = meas.valid && meas.ready;
    assign do_pop     = pop && (count_reg != '0);

    // msb<<12 | lsb<<4 | xlsb>>4
    assign unpacked.adc_p = {meas.press_msb, meas.press_lsb, meas.press_xlsb[7:4]};
    assign unpacked.adc_t = {meas.temp_msb, meas.temp_lsb, meas.temp_xlsb[7:4]};

    // pointers wrap at DEPTH, which need not be a power of two
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next  = count_reg + (AW+1)'(push) - (AW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= unpacked;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.raw   = mem_reg[rd_ptr_reg];

endmodule
`default_nettype wire

/* hw/rtl/bpc_mul64.sv */
// Two-stage 64x64 multiplier keeping the low 64 bits, built from 32-bit partial products.
`default_nettype none
module bpc_mul64 (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    output logic      [63:0] p
);
    logic [63:0] ll_reg, ll_next;
    logic [31:0] cr_reg, cr_next;
    logic [31:0] lh, hl;
    logic [63:0] p_reg, p_next;

    always_comb
    begin
        ll_next = {32'b0, a[31:0]} * {32'b0, b[31:0]};
        lh      = a[31:0] * b[63:32];
        hl      = a[63:32] * b[31:0];
        cr_next = lh + hl;
        p_next  = ll_reg + {cr_reg, 32'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= ll_next;
            cr_reg <= cr_next;
            p_reg  <= p_next;
        end
    end

    assign p = p_reg;

endmodule
`default_nettype wire

/* hw/rtl/bpc_div.sv */
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating.
`default_nettype none
module bpc_div (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [63:0] num,
    input  wire logic [63:0] den,
    output logic      [63:0] quo,
    output logic             zero
);
    localparam int N = bpc_pkg::DATA_W;

    logic [N-1:0] rem_reg  [N+1];
    logic [N-1:0] qd_reg   [N+1];
    logic [N-1:0] mb_reg   [N+1];
    logic         neg_reg  [N+1];
    logic         zero_reg [N+1];
    logic [N-1:0] quo_reg;
    logic         zout_reg;

    // sign handling
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= '0;
            qd_reg[0]   <= num[N-1] ? (~num + 1'b1) : num;
            mb_reg[0]   <= den[N-1] ? (~den + 1'b1) : den;
            neg_reg[0]  <= num[N-1] ^ den[N-1];
            zero_reg[0] <= (den == '0);
        end
    end

    // restoring steps; dividend bits leave qd at the top, quotient bits enter at the bottom
    for (genvar k = 1; k <= N; k++)
    begin : g_step
        logic [N:0] trial;
        logic       ge;
        assign trial = {rem_reg[k-1], qd_reg[k-1][N-1]};
        assign ge    = (trial >= {1'b0, mb_reg[k-1]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? N'(trial - {1'b0, mb_reg[k-1]}) : trial[N-1:0];
                qd_reg[k]   <= {qd_reg[k-1][N-2:0], ge};
                mb_reg[k]   <= mb_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg  <= neg_reg[N] ? (~qd_reg[N] + 1'b1) : qd_reg[N];
            zout_reg <= zero_reg[N];
        end
    end

    assign quo  = quo_reg;
    assign zero = zout_reg;

endmodule
`default_nettype wire

/* hw/rtl/bpc_back.sv */
// Back: temperature and pressure compensation pipeline with output register.
`default_nettype none
module bpc_back (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire bpc_pkg::q_head_t  head,
    input  wire bpc_pkg::cal_t     cal,
    output logic              pop,
    bpc_res_if.source         result
);
    localparam int S_TEMP = bpc_pkg::S_TEMP;
    localparam int S_NUM  = bpc_pkg::S_NUM;
    localparam int S_OUT  = bpc_pkg::S_OUT;

    logic en;
    logic vld_reg [S_OUT];
    logic out_valid_reg;

    assign en  = !out_valid_reg || result.ready;
    assign pop = en && head.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < S_OUT; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= pop;
            for (int k = 1; k < S_OUT; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
            out_valid_reg <= vld_reg[S_OUT-1];
        end
    end

    // ---------------- temperature, 32-bit wrapping ----------------
    bpc_pkg::raw_t raw_reg;
    logic [31:0] ta_reg, d_reg, ma_reg, dd_reg, a_reg, db_reg, fine_reg;
    logic [31:0] ta_next, d_next, ma_next, dd_next, a_next, db_next, fine_next;
    logic [31:0] t2x, t3x, ddsh, dbsh, t5, temp_next;
    logic [63:0] v1_reg, v1_next;
    logic [31:0] temp_line_reg [S_TEMP:S_OUT-1];

    assign t2x       = {{16{cal.t2[15]}}, cal.t2};
    assign t3x       = {{16{cal.t3[15]}}, cal.t3};
    assign ta_next   = {15'b0, raw_reg.adc_t[19:3]} - {15'b0, cal.t1, 1'b0};
    assign d_next    = {16'b0, raw_reg.adc_t[19:4]} - {16'b0, cal.t1};
    assign ma_next   = ta_reg * t2x;
    assign dd_next   = d_reg * d_reg;
    assign a_next    = $signed(ma_reg) >>> 11;
    assign ddsh      = $signed(dd_reg) >>> 12;
    assign db_next   = ddsh * t3x;
    assign dbsh      = $signed(db_reg) >>> 14;
    assign fine_next = a_reg + dbsh;
    assign t5        = fine_reg * 32'd5 + 32'd128;
    assign temp_next = $signed(t5) >>> 8;
    assign v1_next   = {{32{fine_reg[31]}}, fine_reg} - bpc_pkg::FINE_OFFSET;

    // ---------------- pressure, 64-bit wrapping ----------------
    logic [63:0] p1x, p2x, p3x, p4x, p5x, p6x, p7x, p8x, p9x;
    assign p1x = {48'b0, cal.p1};
    assign p2x = bpc_pkg::sx16(cal.p2);
    assign p3x = bpc_pkg::sx16(cal.p3);
    assign p4x = bpc_pkg::sx16(cal.p4);
    assign p5x = bpc_pkg::sx16(cal.p5);
    assign p6x = bpc_pkg::sx16(cal.p6);
    assign p7x = bpc_pkg::sx16(cal.p7);
    assign p8x = bpc_pkg::sx16(cal.p8);
    assign p9x = bpc_pkg::sx16(cal.p9);

    logic [63:0] vv_p, v1p5_p, v1p2_p, vv6_p, vv3_p, p1prod_p, num_p;
    logic [63:0] v1p5_d1_reg, v1p5_d2_reg, v1p2_d1_reg, v1p2_d2_reg;
    logic [63:0] v2_reg, v2_next, v1c_reg, v1c_next, vv3sh;
    logic [63:0] x_reg, x_next, dv_reg, dv_next;
    logic [19:0] adcp_line_reg [1:S_NUM-3];

    bpc_mul64 u_vv   (.clk(clk), .en(en), .a(v1_reg), .b(v1_reg), .p(vv_p));
    bpc_mul64 u_v1p5 (.clk(clk), .en(en), .a(v1_reg), .b(p5x),    .p(v1p5_p));
    bpc_mul64 u_v1p2 (.clk(clk), .en(en), .a(v1_reg), .b(p2x),    .p(v1p2_p));
    bpc_mul64 u_vv6  (.clk(clk), .en(en), .a(vv_p),   .b(p6x),    .p(vv6_p));
    bpc_mul64 u_vv3  (.clk(clk), .en(en), .a(vv_p),   .b(p3x),    .p(vv3_p));
    bpc_mul64 u_p1   (.clk(clk), .en(en), .a(v1c_reg), .b(p1x),   .p(p1prod_p));
    bpc_mul64 u_scl  (.clk(clk), .en(en), .a(x_reg), .b(bpc_pkg::P_SCALE), .p(num_p));

    assign v2_next  = vv6_p + (v1p5_d2_reg << 17) + (p4x << 35);
    assign vv3sh    = $signed(vv3_p) >>> 8;
    assign v1c_next = bpc_pkg::V1_BIAS + vv3sh + (v1p2_d2_reg << 12);
    assign x_next   = ((bpc_pkg::P_OFFSET - {44'b0, adcp_line_reg[S_NUM-3]}) << 31) - v2_reg;
    assign dv_next  = $signed(p1prod_p) >>> 33;

    // ---------------- division and final correction ----------------
    logic [63:0] q_p, ph, w1a_p, w1b_p, w2a_p, w2_next, w1sh;
    logic        zero_p;
    logic [63:0] ph_d1_reg, ph_d2_reg, w2_reg, w2_d_reg;
    logic [63:0] q_line_reg [1:4];
    logic        zero_line_reg [1:5];
    logic [63:0] sum_reg, sum_next, fin, press_full;

    bpc_div u_div (.clk(clk), .en(en), .num(num_p), .den(dv_reg), .quo(q_p), .zero(zero_p));

    assign ph = $signed(q_p) >>> 13;

    bpc_mul64 u_w1a (.clk(clk), .en(en), .a(p9x),   .b(ph),        .p(w1a_p));
    bpc_mul64 u_w1b (.clk(clk), .en(en), .a(w1a_p), .b(ph_d2_reg), .p(w1b_p));
    bpc_mul64 u_w2  (.clk(clk), .en(en), .a(p8x),   .b(q_p),       .p(w2a_p));

    assign w2_next    = $signed(w2a_p) >>> 19;
    assign w1sh       = $signed(w1b_p) >>> 25;
    assign sum_next   = q_line_reg[4] + w1sh + w2_d_reg;
    assign fin        = $signed(sum_reg) >>> 8;
    assign press_full = fin + (p7x << 4);

    logic signed [31:0] out_temp_reg;
    logic [31:0]        out_press_reg;
    logic               out_inv_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            raw_reg  <= head.raw;
            ta_reg   <= ta_next;
            d_reg    <= d_next;
            ma_reg   <= ma_next;
            dd_reg   <= dd_next;
            a_reg    <= a_next;
            db_reg   <= db_next;
            fine_reg <= fine_next;
            v1_reg   <= v1_next;

            temp_line_reg[S_TEMP] <= temp_next;
            for (int k = S_TEMP + 1; k < S_OUT; k++)
            begin
                temp_line_reg[k] <= temp_line_reg[k-1];
            end

            adcp_line_reg[1] <= raw_reg.adc_p;
            for (int k = 2; k <= S_NUM - 3; k++)
            begin
                adcp_line_reg[k] <= adcp_line_reg[k-1];
            end

            v1p5_d1_reg <= v1p5_p;
            v1p5_d2_reg <= v1p5_d1_reg;
            v1p2_d1_reg <= v1p2_p;
            v1p2_d2_reg <= v1p2_d1_reg;
            v2_reg      <= v2_next;
            v1c_reg     <= v1c_next;
            x_reg       <= x_next;
            dv_reg      <= dv_next;

            ph_d1_reg <= ph;
            ph_d2_reg <= ph_d1_reg;
            w2_reg    <= w2_next;
            w2_d_reg  <= w2_reg;
            q_line_reg[1]    <= q_p;
            zero_line_reg[1] <= zero_p;
            for (int k = 2; k <= 4; k++)
            begin
                q_line_reg[k] <= q_line_reg[k-1];
            end
            for (int k = 2; k <= 5; k++)
            begin
                zero_line_reg[k] <= zero_line_reg[k-1];
            end
            sum_reg <= sum_next;

            out_temp_reg  <= temp_line_reg[S_OUT-1];
            out_press_reg <= zero_line_reg[5] ? 32'd0 : press_full[31:0];
            out_inv_reg   <= zero_line_reg[5];
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.temperature_centi = out_temp_reg;
    assign result.pressure_q24_8    = out_press_reg;
    assign result.pressure_invalid  = out_inv_reg;

endmodule
`default_nettype wire
